@@ sv/tks_pkg.sv @@
// Shared types and constants for the token scanner: byte classes, token kinds,
// scan states and the transition table. No dependencies.
`default_nettype none

package tks_pkg;

   localparam int unsigned STATE_BITS = 3;
   localparam int unsigned KIND_BITS  = 3;
   localparam int unsigned CLASS_BITS = 3;

   // byte classes
   localparam logic [CLASS_BITS-1:0] CLS_SQUOTE = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLS_DQUOTE = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLS_DIGIT  = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLS_LETTER = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLS_OTHER  = 3'd4;

   // token kinds
   localparam logic [KIND_BITS-1:0] TOK_NUMRUN  = 3'd0;
   localparam logic [KIND_BITS-1:0] TOK_IDENT   = 3'd1;
   localparam logic [KIND_BITS-1:0] TOK_SQ_ERR  = 3'd2;
   localparam logic [KIND_BITS-1:0] TOK_SQ_STR  = 3'd3;
   localparam logic [KIND_BITS-1:0] TOK_DQ_ERR  = 3'd4;
   localparam logic [KIND_BITS-1:0] TOK_DQ_STR  = 3'd5;

   // scan states
   localparam logic [STATE_BITS-1:0] ST_IDLE    = 3'd0;
   localparam logic [STATE_BITS-1:0] ST_NUMRUN  = 3'd1;
   localparam logic [STATE_BITS-1:0] ST_IDENT   = 3'd2;
   localparam logic [STATE_BITS-1:0] ST_SQ_BODY = 3'd3;
   localparam logic [STATE_BITS-1:0] ST_SQ_DBL  = 3'd4;
   localparam logic [STATE_BITS-1:0] ST_DQ_BODY = 3'd5;
   localparam logic [STATE_BITS-1:0] ST_DQ_SQ   = 3'd6;

   localparam logic [7:0] CHAR_SQUOTE = 8'd39;
   localparam logic [7:0] CHAR_DQUOTE = 8'd34;

   // one transition: either a next state, or the end of a token of some kind
   typedef struct packed {
      logic                  ends;
      logic [STATE_BITS-1:0] code;
   } tks_entry_type;

   function automatic logic [CLASS_BITS-1:0] byte_class(input logic [7:0] ch);
      logic [CLASS_BITS-1:0] cls;
      if (ch == CHAR_SQUOTE)
         cls = CLS_SQUOTE;
      else if (ch == CHAR_DQUOTE)
         cls = CLS_DQUOTE;
      else if (ch >= "0" && ch <= "9")
         cls = CLS_DIGIT;
      else if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z"))
         cls = CLS_LETTER;
      else
         cls = CLS_OTHER;
      return cls;
   endfunction

   function automatic tks_entry_type go(input logic [STATE_BITS-1:0] st);
      return '{ends: 1'b0, code: st};
   endfunction

   function automatic tks_entry_type fin(input logic [KIND_BITS-1:0] kind);
      return '{ends: 1'b1, code: kind};
   endfunction

   function automatic tks_entry_type next_entry(input logic [STATE_BITS-1:0] st,
                                                input logic [CLASS_BITS-1:0] cls);
      tks_entry_type e;
      e = go(ST_IDLE);
      unique case (st)
         ST_NUMRUN: begin
            if (cls == CLS_DIGIT || cls == CLS_LETTER) e = go(ST_NUMRUN);
            else e = fin(TOK_NUMRUN);
         end
         ST_IDENT: begin
            if (cls == CLS_DIGIT || cls == CLS_LETTER) e = go(ST_IDENT);
            else e = fin(TOK_IDENT);
         end
         ST_SQ_BODY: begin
            if (cls == CLS_SQUOTE) e = fin(TOK_SQ_STR);
            else if (cls == CLS_DQUOTE) e = go(ST_SQ_DBL);
            else e = go(ST_SQ_BODY);
         end
         ST_SQ_DBL: begin
            if (cls == CLS_SQUOTE) e = go(ST_SQ_BODY);
            else e = fin(TOK_SQ_ERR);
         end
         ST_DQ_BODY: begin
            if (cls == CLS_SQUOTE) e = go(ST_DQ_SQ);
            else if (cls == CLS_DQUOTE) e = fin(TOK_DQ_STR);
            else e = go(ST_DQ_BODY);
         end
         ST_DQ_SQ: begin
            if (cls == CLS_DQUOTE) e = go(ST_DQ_BODY);
            else e = fin(TOK_DQ_ERR);
         end
         default: begin
            // idle, and unused codes behave as idle
            case (cls)
               CLS_SQUOTE: e = go(ST_SQ_BODY);
               CLS_DQUOTE: e = go(ST_DQ_BODY);
               CLS_DIGIT:  e = go(ST_NUMRUN);
               CLS_LETTER: e = go(ST_IDENT);
               default:    e = go(ST_IDLE);
            endcase
         end
      endcase
      return e;
   endfunction

   // closed strings keep their closing quote; every other kind gives back its last byte
   function automatic logic push_back(input logic [KIND_BITS-1:0] kind);
      return !(kind == TOK_SQ_STR || kind == TOK_DQ_STR);
   endfunction

endpackage

`default_nettype wire

@@ sv/tks_step.sv @@
// One scan step: classify a byte, apply the transition table, resolve a
// pushed-back byte from idle. Pure combinational. Depends on tks_pkg.
`default_nettype none

module tks_step #(
   parameter int unsigned POS_BITS = 16,
   parameter int unsigned LEN_BITS = 12
) (
   input  wire logic [7:0]                    ch,
   input  wire logic [tks_pkg::STATE_BITS-1:0] state_cur,
   input  wire logic [POS_BITS-1:0]           pos_cur,
   input  wire logic [POS_BITS-1:0]           start_cur,
   input  wire logic [LEN_BITS-1:0]           len_cur,
   output logic [tks_pkg::STATE_BITS-1:0]     state_nxt,
   output logic [POS_BITS-1:0]                start_nxt,
   output logic [LEN_BITS-1:0]                len_nxt,
   output logic                               emit,
   output logic [tks_pkg::KIND_BITS-1:0]      emit_kind,
   output logic [POS_BITS-1:0]                emit_start,
   output logic [LEN_BITS-1:0]                emit_len
);

   logic [tks_pkg::CLASS_BITS-1:0] cls;
   logic                           idle;
   logic [POS_BITS-1:0]            start_eff;
   logic [LEN_BITS-1:0]            len_eff;
   logic [LEN_BITS-1:0]            len_inc;
   tks_pkg::tks_entry_type         ent;
   tks_pkg::tks_entry_type         ent_idle;

   always_comb begin
      cls       = tks_pkg::byte_class(ch);
      idle      = (state_cur == tks_pkg::ST_IDLE) || (state_cur > tks_pkg::ST_DQ_SQ);
      start_eff = idle ? pos_cur : start_cur;
      len_eff   = idle ? '0 : len_cur;
      len_inc   = (&len_eff) ? len_eff : len_eff + LEN_BITS'(1);
      ent       = tks_pkg::next_entry(state_cur, cls);
      ent_idle  = tks_pkg::next_entry(tks_pkg::ST_IDLE, cls);

      emit       = ent.ends;
      emit_kind  = ent.code;
      emit_start = start_eff;
      emit_len   = len_inc;
      state_nxt  = ent.code;
      start_nxt  = start_eff;
      len_nxt    = len_inc;

      if (ent.ends) begin
         if (tks_pkg::push_back(ent.code)) begin
            // rescan the ending byte from idle
            emit_len  = len_eff;
            state_nxt = ent_idle.code;
            start_nxt = pos_cur;
            len_nxt   = (ent_idle.code != tks_pkg::ST_IDLE) ? LEN_BITS'(1) : '0;
         end else begin
            state_nxt = tks_pkg::ST_IDLE;
            len_nxt   = '0;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/table_driven_token_scanner.sv @@
// Top level of the table-driven token scanner: scan state registers and the
// result register. Depends on tks_pkg and tks_step.
//
//   channel | direction | handshake          | beat carries
//   req     | in        | req_valid/req_stall | ch
//   rsp     | out       | rsp_valid/rsp_stall | token_kind, token_start, token_length
//
// One byte is taken per cycle while req_stall is low; the token that it closes
// appears on rsp the next cycle, and rsp carries one beat per cycle at most.
// req_stall rises only while a result waits and rsp_stall is high.
// Synchronous reset returns the scanner to idle at stream position zero.
`default_nettype none

module table_driven_token_scanner #(
   parameter int unsigned POS_BITS = 16,
   parameter int unsigned LEN_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_ch,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tks_pkg::KIND_BITS-1:0]          rsp_token_kind,
   output logic [POS_BITS-1:0]                    rsp_token_start,
   output logic [LEN_BITS-1:0]                    rsp_token_length
);

   logic [tks_pkg::STATE_BITS-1:0] state_ff, state_in;
   logic [POS_BITS-1:0]            pos_ff, pos_in;
   logic [POS_BITS-1:0]            start_ff, start_in;
   logic [LEN_BITS-1:0]            len_ff, len_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tks_pkg::KIND_BITS-1:0]  kind_ff;
   logic [POS_BITS-1:0]            tok_start_ff;
   logic [LEN_BITS-1:0]            tok_len_ff;

   logic                           accept;
   logic                           emit;
   logic [tks_pkg::KIND_BITS-1:0]  emit_kind;
   logic [POS_BITS-1:0]            emit_start;
   logic [LEN_BITS-1:0]            emit_len;
   logic [tks_pkg::STATE_BITS-1:0] step_state;
   logic [POS_BITS-1:0]            step_start;
   logic [LEN_BITS-1:0]            step_len;

   tks_step #(
      .POS_BITS (POS_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .ch         (req_ch),
      .state_cur  (state_ff),
      .pos_cur    (pos_ff),
      .start_cur  (start_ff),
      .len_cur    (len_ff),
      .state_nxt  (step_state),
      .start_nxt  (step_start),
      .len_nxt    (step_len),
      .emit       (emit),
      .emit_kind  (emit_kind),
      .emit_start (emit_start),
      .emit_len   (emit_len)
   );

   // hold input only while the result slot is full and not draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = accept ? step_state : state_ff;
      start_in     = accept ? step_start : start_ff;
      len_in       = accept ? step_len : len_ff;
      pos_in       = accept ? pos_ff + POS_BITS'(1) : pos_ff;
      rsp_valid_in = (accept && emit) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tks_pkg::ST_IDLE;
         pos_ff       <= '0;
         start_ff     <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result beat; slot is free whenever accept is high
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff      <= emit_kind;
         tok_start_ff <= emit_start;
         tok_len_ff   <= emit_len;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_start  = tok_start_ff;
   assign rsp_token_length = tok_len_ff;

endmodule

`default_nettype wire
